### src/gzhp_pkg.sv
// Shared types, constants and phase skip logic for the gzip header parser.
`default_nettype none
package gzhp_pkg;

    localparam int unsigned MAX_STRING  = 4096;
    localparam int unsigned STR_W       = 13;
    localparam int unsigned OFFSET_W    = 17;
    localparam int unsigned FIXED_LEN   = 10;
    localparam int unsigned TRAILER_LEN = 8;

    localparam logic [STR_W-1:0] STR_CAP = STR_W'(MAX_STRING);

    // header flag bit positions
    localparam int unsigned FL_HCRC_BIT    = 1;
    localparam int unsigned FL_EXTRA_BIT   = 2;
    localparam int unsigned FL_NAME_BIT    = 3;
    localparam int unsigned FL_COMMENT_BIT = 4;

    // compression method codes
    localparam logic [7:0] CM_DEFLATE = 8'd8;
    localparam logic [7:0] CM_STORED  = 8'd0;
    localparam logic [1:0] METHOD_DEFLATE = 2'd0;
    localparam logic [1:0] METHOD_STORED  = 2'd1;
    localparam logic [1:0] METHOD_UNKNOWN = 2'd2;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_XLEN,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_HCRC,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } gzhp_in_t;

    typedef struct packed {
        logic [1:0]          method_code;
        logic [7:0]          flag_bits;
        logic [31:0]         mod_time;
        logic [7:0]          extra_flags;
        logic [7:0]          os_code;
        logic [STR_W-1:0]    name_length;
        logic [STR_W-1:0]    comment_length;
        logic [OFFSET_W-1:0] payload_offset;
        logic                header_truncated;
        logic                trailer_present;
        logic [31:0]         stored_crc;
        logic [31:0]         original_size;
    } gzhp_out_t;

    // First section at or after p that is actually present in the stream.
    function automatic phase_t skip_phase(phase_t p, logic [7:0] flags, logic extra_zero);
        phase_t q;
        q = p;
        if (q == PH_XLEN && !flags[FL_EXTRA_BIT])
            q = PH_NAME;
        if (q == PH_EXTRA && extra_zero)
            q = PH_NAME;
        if (q == PH_NAME && !flags[FL_NAME_BIT])
            q = PH_COMMENT;
        if (q == PH_COMMENT && !flags[FL_COMMENT_BIT])
            q = PH_HCRC;
        if (q == PH_HCRC && !flags[FL_HCRC_BIT])
            q = PH_DATA;
        return q;
    endfunction

endpackage
`default_nettype wire

### src/gzip_header_parser_core.sv
// Top level of the gzip member header parser: byte intake, parse state and result register.
//
// Usage: one gzip member is fed as a stream of bytes on the src channel
// (src_valid / src_stall / src_item). Each item carries one stream byte and
// a flag that marks the final byte of the member. Bytes without that flag
// produce nothing; the final byte produces one result item on the res
// channel holding the header fields, name and comment lengths, the payload
// offset and the trailer CRC32 / ISIZE.
// Timing: an item is captured in an input register; from there the parse
// state is updated and, for the final byte, the result register is loaded,
// which drives res_valid / res_item directly.
// One byte per cycle is accepted while src_stall is low; the parse
// registers take one state update per processed byte.
// src_stall rises only when a final byte waits in the input register while
// the previous result is still held under res_stall; ordinary bytes keep
// flowing while a result waits.
// Reset clears all parse state to the start of a new member and empties
// both registers. After each final byte the parser returns to that state.
`default_nettype none
module gzip_header_parser_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output      logic              src_stall,
    input  wire gzhp_pkg::gzhp_in_t  src_item,
    output      logic              res_valid,
    input  wire logic              res_stall,
    output      gzhp_pkg::gzhp_out_t res_item
);
    import gzhp_pkg::*;

    // input register
    logic     in_valid_reg;
    gzhp_in_t in_item_reg;

    // parse state
    phase_t              phase_reg,   phase_next;
    logic [3:0]          fcount_reg,  fcount_next;
    logic [7:0]          flags_reg,   flags_next;
    logic [1:0]          method_reg,  method_next;
    logic [31:0]         time_reg,    time_next;
    logic [7:0]          xfl_reg,     xfl_next;
    logic [7:0]          os_reg,      os_next;
    logic [15:0]         extra_reg,   extra_next;
    logic [STR_W-1:0]    name_reg,    name_next;
    logic [STR_W-1:0]    comment_reg, comment_next;
    logic [OFFSET_W-1:0] offset_reg,  offset_next;
    logic [31:0]         count_reg,   count_next;
    logic [63:0]         tail_reg,    tail_next;

    // result register
    logic      res_valid_reg;
    gzhp_out_t res_item_reg;
    gzhp_out_t result;

    logic       proc_ok;
    logic       take_in;
    logic [7:0] c;
    logic [STR_W-1:0] name_inc;
    logic [STR_W-1:0] comment_inc;
    logic [15:0]      extra_dec;
    logic             complete;
    logic [31:0]      off_limit;

    assign c           = in_item_reg.data_byte;
    assign name_inc    = name_reg + STR_W'(1);
    assign comment_inc = comment_reg + STR_W'(1);
    assign extra_dec   = (extra_reg != 16'd0) ? extra_reg - 16'd1 : extra_reg;

    // a final byte can only be processed when the result register is free
    assign proc_ok   = in_valid_reg &&
                       (!in_item_reg.last_byte || !res_valid_reg || !res_stall);
    assign take_in   = !in_valid_reg || proc_ok;
    assign src_stall = !take_in;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_FIXED:
            begin
                if (fcount_reg == 4'(FIXED_LEN - 1))
                    phase_next = skip_phase(PH_XLEN, flags_reg, 1'b0);
            end
            PH_XLEN:
            begin
                if (fcount_reg != 4'd0)
                    phase_next = skip_phase(PH_EXTRA, flags_reg,
                                            ({c, extra_reg[7:0]} == 16'd0));
            end
            PH_EXTRA:
            begin
                if (extra_dec == 16'd0)
                    phase_next = skip_phase(PH_NAME, flags_reg, 1'b0);
            end
            PH_NAME:
            begin
                if (c == 8'd0 || name_inc >= STR_CAP)
                    phase_next = skip_phase(PH_COMMENT, flags_reg, 1'b0);
            end
            PH_COMMENT:
            begin
                if (c == 8'd0 || comment_inc >= STR_CAP)
                    phase_next = skip_phase(PH_HCRC, flags_reg, 1'b0);
            end
            PH_HCRC:
            begin
                if (fcount_reg != 4'd0)
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                phase_next = PH_DATA;
            end
            default:
            begin
                phase_next = PH_FIXED;
            end
        endcase
    end

    // field registers
    always_comb
    begin
        fcount_next  = fcount_reg;
        flags_next   = flags_reg;
        method_next  = method_reg;
        time_next    = time_reg;
        xfl_next     = xfl_reg;
        os_next      = os_reg;
        extra_next   = extra_reg;
        name_next    = name_reg;
        comment_next = comment_reg;
        offset_next  = offset_reg;
        count_next   = (count_reg != 32'hFFFF_FFFF) ? count_reg + 32'd1 : count_reg;
        tail_next    = {tail_reg[55:0], c};

        unique case (phase_reg)
            PH_FIXED:
            begin
                unique case (fcount_reg)
                    4'd2:
                    begin
                        if (c == CM_DEFLATE)
                            method_next = METHOD_DEFLATE;
                        else if (c == CM_STORED)
                            method_next = METHOD_STORED;
                        else
                            method_next = METHOD_UNKNOWN;
                    end
                    4'd3: flags_next = c;
                    4'd4: time_next[7:0]   = c;
                    4'd5: time_next[15:8]  = c;
                    4'd6: time_next[23:16] = c;
                    4'd7: time_next[31:24] = c;
                    4'd8: xfl_next = c;
                    4'd9: os_next  = c;
                    default: ;
                endcase
            end
            PH_XLEN:
            begin
                if (fcount_reg == 4'd0)
                    extra_next = {8'd0, c};
                else
                    extra_next = {c, extra_reg[7:0]};
            end
            PH_EXTRA:
            begin
                extra_next = extra_dec;
            end
            PH_NAME:
            begin
                if (c != 8'd0)
                    name_next = name_inc;
            end
            PH_COMMENT:
            begin
                if (c != 8'd0)
                    comment_next = comment_inc;
            end
            default: ;
        endcase

        if (phase_next != phase_reg)
            fcount_next = 4'd0;
        else if (phase_reg == PH_FIXED || phase_reg == PH_XLEN || phase_reg == PH_HCRC)
            fcount_next = fcount_reg + 4'd1;

        if (phase_next == PH_DATA && phase_reg != PH_DATA)
            offset_next = count_next[OFFSET_W-1:0];
    end

    // result built from the state as it stands after the final byte
    assign complete  = (phase_next == PH_DATA);
    assign off_limit = 32'(offset_next) + 32'(TRAILER_LEN);

    always_comb
    begin
        result.method_code      = method_next;
        result.flag_bits        = flags_next;
        result.mod_time         = time_next;
        result.extra_flags      = xfl_next;
        result.os_code          = os_next;
        result.name_length      = name_next;
        result.comment_length   = comment_next;
        result.payload_offset   = complete ? offset_next : count_next[OFFSET_W-1:0];
        result.header_truncated = !complete;
        result.trailer_present  = complete && (count_next >= off_limit);
        if (result.trailer_present)
        begin
            result.stored_crc    = {tail_next[39:32], tail_next[47:40],
                                    tail_next[55:48], tail_next[63:56]};
            result.original_size = {tail_next[7:0], tail_next[15:8],
                                    tail_next[23:16], tail_next[31:24]};
        end
        else
        begin
            result.stored_crc    = 32'd0;
            result.original_size = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in && src_valid)
            in_item_reg <= src_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIXED;
            fcount_reg  <= '0;
            flags_reg   <= '0;
            method_reg  <= '0;
            time_reg    <= '0;
            xfl_reg     <= '0;
            os_reg      <= '0;
            extra_reg   <= '0;
            name_reg    <= '0;
            comment_reg <= '0;
            offset_reg  <= '0;
            count_reg   <= '0;
            tail_reg    <= '0;
        end
        else if (proc_ok)
        begin
            if (in_item_reg.last_byte)
            begin
                // member done: back to the start-of-member state
                phase_reg   <= PH_FIXED;
                fcount_reg  <= '0;
                flags_reg   <= '0;
                method_reg  <= '0;
                time_reg    <= '0;
                xfl_reg     <= '0;
                os_reg      <= '0;
                extra_reg   <= '0;
                name_reg    <= '0;
                comment_reg <= '0;
                offset_reg  <= '0;
                count_reg   <= '0;
                tail_reg    <= '0;
            end
            else
            begin
                phase_reg   <= phase_next;
                fcount_reg  <= fcount_next;
                flags_reg   <= flags_next;
                method_reg  <= method_next;
                time_reg    <= time_next;
                xfl_reg     <= xfl_next;
                os_reg      <= os_next;
                extra_reg   <= extra_next;
                name_reg    <= name_next;
                comment_reg <= comment_next;
                offset_reg  <= offset_next;
                count_reg   <= count_next;
                tail_reg    <= tail_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (proc_ok && in_item_reg.last_byte)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_ok && in_item_reg.last_byte)
            res_item_reg <= result;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // final byte always returns the parser to the start of a member
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        proc_ok && in_item_reg.last_byte |=> phase_reg == PH_FIXED && count_reg == 32'd0)
        else $error("parser did not restart after final byte");

    // payload offset is only recorded on entry to the data section
    a_offset: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_DATA |-> offset_reg == '0)
        else $error("payload offset set before header end");

    // input side only blocks behind a held result
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> in_valid_reg && in_item_reg.last_byte && res_valid_reg && res_stall)
        else $error("input stalled without a blocked result");

    // a truncated header can never report a trailer
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_item_reg.header_truncated |-> !res_item_reg.trailer_present)
        else $error("trailer reported on truncated header");

    a_fcount: assert property (@(posedge clk) disable iff (!rst_n)
        fcount_reg < 4'(FIXED_LEN))
        else $error("field counter out of range");

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the gzip member header parser core.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import gzhp_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1550;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 20;

    // directed bytes: single final byte, short unknown-method header,
    // and a header cut inside XLEN with all flags, MTIME and XFL at their top value
    localparam gzhp_in_t DIRECTED [22] = '{
        '{8'hFF, 1'b1},
        '{8'h1F, 1'b0}, '{8'h8B, 1'b0}, '{8'h03, 1'b0}, '{8'h00, 1'b0},
        '{8'h78, 1'b0}, '{8'h56, 1'b0}, '{8'h34, 1'b0}, '{8'h12, 1'b0},
        '{8'h00, 1'b0}, '{8'hFF, 1'b1},
        '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{CM_STORED, 1'b0}, '{8'hFF, 1'b0},
        '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0}, '{8'hFF, 1'b0},
        '{8'hFF, 1'b0}, '{8'h00, 1'b0}, '{8'h05, 1'b1}
    };

    localparam gzhp_out_t DIRECTED_WANT [3] = '{
        '{METHOD_DEFLATE, 8'h00, 32'h0, 8'h00, 8'h00, 13'd0, 13'd0, 17'd1,
          1'b1, 1'b0, 32'h0, 32'h0},
        '{METHOD_UNKNOWN, 8'h00, 32'h12345678, 8'h00, 8'hFF, 13'd0, 13'd0, 17'd10,
          1'b0, 1'b0, 32'h0, 32'h0},
        '{METHOD_STORED, 8'hFF, 32'hFFFFFFFF, 8'hFF, 8'h00, 13'd0, 13'd0, 17'd11,
          1'b1, 1'b0, 32'h0, 32'h0}
    };

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    gzhp_in_t  src_item;
    logic      res_valid;
    logic      res_stall;
    gzhp_out_t res_item;

    logic      rx_stall;
    logic      hold_off;

    assign res_stall = rx_stall | hold_off;

    gzip_header_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // header parse state mirrored for prediction
    phase_t      hdr_phase;
    int unsigned hdr_cnt;
    logic [7:0]  hdr_flags;
    logic [1:0]  hdr_method;
    logic [31:0] hdr_mtime;
    logic [7:0]  hdr_xfl;
    logic [7:0]  hdr_os;
    logic [15:0] hdr_xrem;
    logic [12:0] hdr_nlen;
    logic [12:0] hdr_clen;
    logic [16:0] hdr_doff;
    logic [31:0] hdr_count;
    logic [63:0] hdr_tail;

    gzhp_out_t   member_summaries [$];
    logic [7:0]  member_bytes [$];
    gzhp_out_t   arrived;

    bit          typed_mode;
    int          typed_idx;
    bit          tx_burst;
    bit          rx_burst;
    bit          pressure_go;
    int unsigned random_sent;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    function automatic void hdr_clear();
        hdr_phase = PH_FIXED;
        hdr_cnt   = 0;
        hdr_flags = '0;
        hdr_method = METHOD_DEFLATE;
        hdr_mtime = '0;
        hdr_xfl   = '0;
        hdr_os    = '0;
        hdr_xrem  = '0;
        hdr_nlen  = '0;
        hdr_clen  = '0;
        hdr_doff  = '0;
        hdr_count = '0;
        hdr_tail  = '0;
    endfunction

    // move to the first section at or after p that the flags say is present
    function automatic void hdr_enter(input phase_t p);
        phase_t q;
        bit     settled;
        q = p;
        settled = 1'b0;
        while (!settled) begin
            case (q)
                PH_XLEN:    if (!hdr_flags[FL_EXTRA_BIT]) q = PH_NAME; else settled = 1'b1;
                PH_EXTRA:   if (hdr_xrem == 0) q = PH_NAME; else settled = 1'b1;
                PH_NAME:    if (!hdr_flags[FL_NAME_BIT]) q = PH_COMMENT; else settled = 1'b1;
                PH_COMMENT: if (!hdr_flags[FL_COMMENT_BIT]) q = PH_HCRC; else settled = 1'b1;
                PH_HCRC:    if (!hdr_flags[FL_HCRC_BIT]) q = PH_DATA; else settled = 1'b1;
                default:    settled = 1'b1;
            endcase
        end
        hdr_cnt = 0;
        hdr_phase = q;
        if (q == PH_DATA)
            hdr_doff = hdr_count[16:0];
    endfunction

    // advance the header state by one byte; returns 1 with the summary on the final byte
    function automatic bit parse_gzip_byte(input gzhp_in_t it, output gzhp_out_t r);
        logic [7:0]  c;
        bit          complete;
        logic [32:0] off;
        c = it.data_byte;
        if (hdr_count != 32'hFFFFFFFF)
            hdr_count = hdr_count + 1;
        hdr_tail = {hdr_tail[55:0], c};
        case (hdr_phase)
            PH_FIXED:
            begin
                case (hdr_cnt)
                    2: hdr_method = (c == CM_DEFLATE) ? METHOD_DEFLATE :
                                    (c == CM_STORED) ? METHOD_STORED : METHOD_UNKNOWN;
                    3: hdr_flags = c;
                    4, 5, 6, 7: hdr_mtime = hdr_mtime | (32'(c) << (8 * (hdr_cnt - 4)));
                    8: hdr_xfl = c;
                    9: hdr_os = c;
                    default: ;
                endcase
                hdr_cnt = hdr_cnt + 1;
                if (hdr_cnt >= FIXED_LEN)
                    hdr_enter(PH_XLEN);
            end
            PH_XLEN:
            begin
                if (hdr_cnt == 0)
                begin
                    hdr_xrem = {8'h00, c};
                    hdr_cnt = 1;
                end
                else
                begin
                    hdr_xrem[15:8] = c;
                    hdr_enter(PH_EXTRA);
                end
            end
            PH_EXTRA:
            begin
                if (hdr_xrem != 0)
                    hdr_xrem = hdr_xrem - 1;
                if (hdr_xrem == 0)
                    hdr_enter(PH_NAME);
            end
            PH_NAME:
            begin
                if (c == 8'h00)
                    hdr_enter(PH_COMMENT);
                else
                begin
                    hdr_nlen = hdr_nlen + 1;
                    if (hdr_nlen >= MAX_STRING)
                        hdr_enter(PH_COMMENT);
                end
            end
            PH_COMMENT:
            begin
                if (c == 8'h00)
                    hdr_enter(PH_HCRC);
                else
                begin
                    hdr_clen = hdr_clen + 1;
                    if (hdr_clen >= MAX_STRING)
                        hdr_enter(PH_HCRC);
                end
            end
            PH_HCRC:
            begin
                hdr_cnt = hdr_cnt + 1;
                if (hdr_cnt >= 2)
                    hdr_enter(PH_DATA);
            end
            default: ;
        endcase
        if (!it.last_byte)
            return 1'b0;
        complete = (hdr_phase == PH_DATA);
        off = complete ? 33'(hdr_doff) : 33'(hdr_count);
        r.method_code      = hdr_method;
        r.flag_bits        = hdr_flags;
        r.mod_time         = hdr_mtime;
        r.extra_flags      = hdr_xfl;
        r.os_code          = hdr_os;
        r.name_length      = hdr_nlen;
        r.comment_length   = hdr_clen;
        r.payload_offset   = off[16:0];
        r.header_truncated = !complete;
        r.trailer_present  = 33'(hdr_count) >= off + 33'(TRAILER_LEN);
        if (r.trailer_present)
        begin
            r.stored_crc    = {hdr_tail[39:32], hdr_tail[47:40], hdr_tail[55:48], hdr_tail[63:56]};
            r.original_size = {hdr_tail[7:0], hdr_tail[15:8], hdr_tail[23:16], hdr_tail[31:24]};
        end
        else
        begin
            r.stored_crc    = '0;
            r.original_size = '0;
        end
        hdr_clear();
        return 1'b1;
    endfunction

    function automatic void add_bytes(input int n, input bit nonzero);
        for (int i = 0; i < n; i++)
            member_bytes.push_back(nonzero ? 8'($urandom_range(1, 255)) : 8'($urandom_range(0, 255)));
    endfunction

    // one member: mostly well formed with random content, some cut short, some pure noise
    task automatic make_member();
        int          kind;
        int          xlen;
        int          cut;
        logic [7:0]  flg;
        member_bytes = {};
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            add_bytes($urandom_range(1, 24), 1'b0);
            return;
        end
        member_bytes.push_back(8'h1F);
        member_bytes.push_back(8'h8B);
        case ($urandom_range(0, 3))
            0, 1: member_bytes.push_back(CM_DEFLATE);
            2:    member_bytes.push_back(CM_STORED);
            default: member_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 3) == 0)
            flg = 8'($urandom_range(0, 255));
        else
            flg = 8'($urandom_range(0, 31));
        member_bytes.push_back(flg);
        add_bytes(6, 1'b0);
        if (flg[FL_EXTRA_BIT])
        begin
            xlen = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 12);
            member_bytes.push_back(xlen[7:0]);
            member_bytes.push_back(xlen[15:8]);
            add_bytes(xlen, 1'b0);
        end
        if (flg[FL_NAME_BIT])
        begin
            add_bytes($urandom_range(0, 8), 1'b1);
            member_bytes.push_back(8'h00);
        end
        if (flg[FL_COMMENT_BIT])
        begin
            add_bytes($urandom_range(0, 8), 1'b1);
            member_bytes.push_back(8'h00);
        end
        if (flg[FL_HCRC_BIT])
            add_bytes(2, 1'b0);
        add_bytes($urandom_range(0, 30), 1'b0);
        if (kind < 25)
        begin
            cut = $urandom_range(1, member_bytes.size());
            while (member_bytes.size() > cut)
                void'(member_bytes.pop_back());
        end
    endtask

    task automatic send_item(input gzhp_in_t it);
        int        gap;
        gzhp_out_t pred;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        if (parse_gzip_byte(it, pred))
        begin
            if (typed_mode)
            begin
                member_summaries.push_back(DIRECTED_WANT[typed_idx]);
                typed_idx++;
            end
            else
                member_summaries.push_back(pred);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (member_summaries.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result item: %p", res_item);
            end
            else
            begin
                arrived = member_summaries.pop_front();
                check_field("method_code", 32'(arrived.method_code), 32'(res_item.method_code));
                check_field("flag_bits", 32'(arrived.flag_bits), 32'(res_item.flag_bits));
                check_field("mod_time", arrived.mod_time, res_item.mod_time);
                check_field("extra_flags", 32'(arrived.extra_flags), 32'(res_item.extra_flags));
                check_field("os_code", 32'(arrived.os_code), 32'(res_item.os_code));
                check_field("name_length", 32'(arrived.name_length),
                            32'(res_item.name_length));
                check_field("comment_length", 32'(arrived.comment_length),
                            32'(res_item.comment_length));
                check_field("payload_offset", 32'(arrived.payload_offset),
                            32'(res_item.payload_offset));
                check_field("header_truncated", 32'(arrived.header_truncated),
                            32'(res_item.header_truncated));
                check_field("trailer_present", 32'(arrived.trailer_present),
                            32'(res_item.trailer_present));
                check_field("stored_crc", arrived.stored_crc, res_item.stored_crc);
                check_field("original_size", arrived.original_size, res_item.original_size);
            end
        end
    end

    // result side: random wait per item, with runs of no waiting
    initial
    begin
        int n;
        rx_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                rx_burst = !rx_burst;
            n = rx_burst ? 0 : $urandom_range(0, 12);
            if (n > 0)
            begin
                rx_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rx_stall <= 1'b0;
            @(posedge clk);
            while (!(res_valid && !res_stall))
                @(posedge clk);
        end
    end

    // long hold-off on results so back-to-back members back up into the input
    initial
    begin
        hold_off <= 1'b0;
        wait (pressure_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int  members;
        gzhp_in_t it;
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        src_item  <= '0;
        hdr_clear();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        typed_mode = 1'b1;
        tx_burst = 1'b0;
        for (int i = 0; i < $size(DIRECTED); i++)
            send_item(DIRECTED[i]);
        typed_mode = 1'b0;

        pressure_go = 1'b1;
        members = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            tx_burst = (members < 3) || ($urandom_range(0, 3) == 0);
            make_member();
            for (int k = 0; k < member_bytes.size(); k++)
            begin
                it.data_byte = member_bytes[k];
                it.last_byte = (k == member_bytes.size() - 1);
                send_item(it);
                random_sent++;
            end
            members++;
        end
        src_valid <= 1'b0;

        while (member_summaries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire

### sim.f
src/gzhp_pkg.sv
src/gzip_header_parser_core.sv
bench/tb_top.sv
